@@ hdl/dgsl_pkg.sv @@
// Types and constants shared by the slope limiter pipeline.
// No dependencies; used by dgsl_hstep and dg_slope_limiter.
package dgsl_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int EW = DATA_WIDTH + 1;   // exact neighbor differences
	localparam int MW = DATA_WIDTH + 3;   // candidate slopes before saturation
	localparam int RW = DATA_WIDTH + 3;   // divider partial remainder
	localparam int QW = DATA_WIDTH + 2;   // van Leer magnitude

	localparam logic [1:0] MODE_MINMOD   = 2'd0;
	localparam logic [1:0] MODE_VANLEER  = 2'd1;
	localparam logic [1:0] MODE_MC       = 2'd2;
	localparam logic [1:0] MODE_SUPERBEE = 2'd3;

	localparam logic [1:0] REG_LIMITER_MODE  = 2'd0;
	localparam logic [1:0] REG_LIMIT_Y_EN    = 2'd1;
	localparam logic [1:0] REG_LEFT_BOUNDARY = 2'd2;
	localparam logic [1:0] REG_RIGHT_BOUNDARY = 2'd3;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] cell_mean;
		logic signed [DATA_WIDTH-1:0] x_slope;
		logic signed [DATA_WIDTH-1:0] left_mean;
		logic                         has_left;
		logic signed [DATA_WIDTH-1:0] right_mean;
		logic                         has_right;
		logic signed [DATA_WIDTH-1:0] y_slope;
		logic                         has_y_slope;
		logic signed [DATA_WIDTH-1:0] bottom_mean;
		logic                         has_bottom;
		logic signed [DATA_WIDTH-1:0] top_mean;
		logic                         has_top;
	} cell_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] x_slope_out;
		logic                         x_changed;
		logic signed [DATA_WIDTH-1:0] y_slope_out;
		logic                         y_changed;
	} result_t;

	// State of the harmonic-mean divider: floor(2*x*y / (x + y)).
	typedef struct packed {
		logic [EW-1:0]         x2;
		logic [EW-1:0]         d;
		logic [DATA_WIDTH-1:0] y;
		logic [RW-1:0]         r;
		logic [QW-1:0]         q;
	} div_t;

	typedef struct packed {
		div_t                         div;
		logic [1:0]                   mode;
		logic signed [DATA_WIDTH-1:0] sx;
		logic signed [MW-1:0]         lx_pre;
		logic                         vl_ok;
		logic                         vl_neg;
		logic signed [DATA_WIDTH-1:0] y_out;
		logic                         y_chg;
	} pipe_t;

endpackage

@@ hdl/dgsl_hstep.sv @@
// One pipeline stage of the harmonic-mean divider: one bit of y per stage.
// Depends on dgsl_pkg.
module dgsl_hstep #(
	parameter int BIT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_stall,
	input  dgsl_pkg::pipe_t up_data,
	output logic            dn_valid,
	input  logic            dn_stall,
	output dgsl_pkg::pipe_t dn_data
);

	logic            valid_q;
	dgsl_pkg::pipe_t data_q;
	dgsl_pkg::pipe_t nxt;
	logic [dgsl_pkg::RW-1:0] t, d1, d2, d3;
	logic [1:0] k;

	assign up_stall = valid_q && dn_stall;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	// Shift in the next bit of y times 2x; the remainder stays below 4d,
	// so at most three subtractions of d are needed.
	always_comb begin
		nxt = up_data;
		t  = {up_data.div.r[dgsl_pkg::RW-2:0], 1'b0}
			+ (up_data.div.y[BIT] ? dgsl_pkg::RW'(up_data.div.x2) : '0);
		d1 = dgsl_pkg::RW'(up_data.div.d);
		d2 = {d1[dgsl_pkg::RW-2:0], 1'b0};
		d3 = d1 + d2;
		if (t >= d3) begin
			k = 2'd3;
			nxt.div.r = t - d3;
		end else if (t >= d2) begin
			k = 2'd2;
			nxt.div.r = t - d2;
		end else if (t >= d1) begin
			k = 2'd1;
			nxt.div.r = t - d1;
		end else begin
			k = 2'd0;
			nxt.div.r = t;
		end
		nxt.div.q = {up_data.div.q[dgsl_pkg::QW-2:0], 1'b0} + dgsl_pkg::QW'(k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall) begin
			data_q <= nxt;
		end
	end

endmodule

@@ hdl/dg_slope_limiter.sv @@
// Slope limiter top level. Depends on dgsl_pkg and dgsl_hstep.
// Registers in order: s1, s2, s3, the divider chain, s4; takes one cell per cycle unless stalled.
// The van Leer divider sets the depth: one quotient step per stage, one stage per bit.
// Each stage holds while the one after it is full and stalled, so bubbles fill up.
// Reset clears all valid bits and sets every config register to 0 (minmod, y limiting off).
module dg_slope_limiter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cell_valid,
	output logic                 cell_stall,
	input  dgsl_pkg::cell_t      cell_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output dgsl_pkg::result_t    res,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [dgsl_pkg::DATA_WIDTH-1:0] cfg_data
);

	localparam int DW = dgsl_pkg::DATA_WIDTH;
	localparam int EW = dgsl_pkg::EW;
	localparam int MW = dgsl_pkg::MW;

	typedef logic signed [MW-1:0] wide_t;

	function automatic wide_t mag(input wide_t v);
		mag = (v < 0) ? -v : v;
	endfunction

	function automatic logic same_sign(input wide_t a, input wide_t b);
		same_sign = (a > 0 && b > 0) || (a < 0 && b < 0);
	endfunction

	function automatic wide_t mm2(input wide_t a, input wide_t b);
		if (!same_sign(a, b)) mm2 = '0;
		else mm2 = (mag(a) < mag(b)) ? a : b;
	endfunction

	function automatic wide_t mm3(input wide_t a, input wide_t b, input wide_t c);
		wide_t m;
		m = mag(a);
		if (mag(b) < m) m = mag(b);
		if (mag(c) < m) m = mag(c);
		if (!same_sign(a, b) || !same_sign(a, c)) mm3 = '0;
		else mm3 = (a > 0) ? m : -m;
	endfunction

	// Configuration registers.
	logic [1:0]           mode_q;
	logic                 yen_q;
	logic signed [DW-1:0] left_bnd_q, right_bnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= dgsl_pkg::MODE_MINMOD;
			yen_q       <= 1'b0;
			left_bnd_q  <= '0;
			right_bnd_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dgsl_pkg::REG_LIMITER_MODE:   mode_q      <= cfg_data[1:0];
				dgsl_pkg::REG_LIMIT_Y_EN:     yen_q       <= cfg_data[0];
				dgsl_pkg::REG_LEFT_BOUNDARY:  left_bnd_q  <= cfg_data;
				dgsl_pkg::REG_RIGHT_BOUNDARY: right_bnd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: neighbor selection and exact differences.
	logic valid_s1, stall_s1;
	logic signed [EW-1:0] dp_s1, dm_s1, dt_s1, db_s1;
	logic signed [DW-1:0] sx_s1, sy_s1;
	logic has_y_s1, yen_s1;
	logic [1:0] mode_s1;
	logic signed [DW-1:0] left_c, right_c, bot_c, top_c;

	// Stage 2: two-way and three-way minmods, MC operands.
	logic valid_s2, stall_s2;
	wide_t xmm_s2, ymm_s2, sb1_s2, sb2_s2, mca_s2, mcb_s2, mcc_s2;
	logic signed [EW-1:0] dp_s2, dm_s2;
	logic signed [DW-1:0] sx_s2, sy_s2;
	logic has_y_s2, yen_s2;
	logic [1:0] mode_s2;
	wide_t sum_c, half_c;

	// Stage 3: mode selection and divider setup.
	logic valid_s3, stall_s3;
	dgsl_pkg::pipe_t data_s3, p3_c;
	wide_t mc_c, sb_c, sbc_c, sxw_c, xabs_c, yabs_c;

	// Divider chain; index 0 is stage 3.
	logic            chain_v [0:DW];
	logic            chain_stall [0:DW];
	dgsl_pkg::pipe_t chain_d [0:DW];

	// Stage 4: clamp, saturation and the result register.
	logic valid_s4, stall_s4;
	dgsl_pkg::result_t res_s4, r4_c;
	wide_t vl_c, vlc_c, lx_c;
	dgsl_pkg::pipe_t last_c;

	assign stall_s4 = valid_s4 && res_stall;
	assign chain_stall[DW] = stall_s4;
	assign stall_s3 = valid_s3 && chain_stall[0];
	assign stall_s2 = valid_s2 && stall_s3;
	assign stall_s1 = valid_s1 && stall_s2;
	assign cell_stall = stall_s1;

	always_comb begin
		left_c  = cell_data.has_left   ? cell_data.left_mean   : left_bnd_q;
		right_c = cell_data.has_right  ? cell_data.right_mean  : right_bnd_q;
		bot_c   = cell_data.has_bottom ? cell_data.bottom_mean : '0;
		top_c   = cell_data.has_top    ? cell_data.top_mean    : '0;
	end

	always_comb begin
		sum_c  = MW'(dm_s1) + MW'(dp_s1);
		// Halving truncates toward zero.
		half_c = (sum_c + wide_t'(sum_c < 0)) >>> 1;
	end

	always_comb begin
		sxw_c  = MW'(sx_s2);
		mc_c   = mm3(mca_s2, mcb_s2, mcc_s2);
		sb_c   = (mag(sb1_s2) >= mag(sb2_s2)) ? sb1_s2 : sb2_s2;
		sbc_c  = (mag(sb_c) > mag(sxw_c)) ? sxw_c : sb_c;
		xabs_c = mag(MW'(dm_s2));
		yabs_c = mag(MW'(dp_s2));
		p3_c = '0;
		p3_c.mode = mode_s2;
		p3_c.sx   = sx_s2;
		case (mode_s2)
			dgsl_pkg::MODE_MC:       p3_c.lx_pre = mc_c;
			dgsl_pkg::MODE_SUPERBEE: p3_c.lx_pre = sbc_c;
			dgsl_pkg::MODE_VANLEER:  p3_c.lx_pre = '0;
			default:                 p3_c.lx_pre = xmm_s2;
		endcase
		p3_c.vl_ok  = same_sign(MW'(dm_s2), MW'(dp_s2));
		p3_c.vl_neg = dm_s2 < 0;
		p3_c.div.x2 = {xabs_c[DW-1:0], 1'b0};
		p3_c.div.y  = yabs_c[DW-1:0];
		p3_c.div.d  = EW'(xabs_c[DW-1:0]) + EW'(yabs_c[DW-1:0]);
		p3_c.div.r  = '0;
		p3_c.div.q  = '0;
		if (!has_y_s2) begin
			p3_c.y_out = '0;
			p3_c.y_chg = 1'b0;
		end else if (!yen_s2) begin
			p3_c.y_out = sy_s2;
			p3_c.y_chg = 1'b0;
		end else begin
			// A minmod result never exceeds |y slope|, so it fits.
			p3_c.y_out = ymm_s2[DW-1:0];
			p3_c.y_chg = ymm_s2[DW-1:0] != sy_s2;
		end
	end

	always_comb begin
		last_c = chain_d[DW];
		vl_c = last_c.vl_ok ? MW'(last_c.div.q) : '0;
		if (last_c.vl_neg) vl_c = -vl_c;
		vlc_c = (mag(vl_c) > mag(MW'(last_c.sx))) ? MW'(last_c.sx) : vl_c;
		lx_c = (last_c.mode == dgsl_pkg::MODE_VANLEER) ? vlc_c : last_c.lx_pre;
		r4_c.y_slope_out = last_c.y_out;
		r4_c.y_changed   = last_c.y_chg;
		if ((&lx_c[MW-1:DW-1]) || !(|lx_c[MW-1:DW-1])) begin
			r4_c.x_slope_out = lx_c[DW-1:0];
		end else if (lx_c[MW-1]) begin
			r4_c.x_slope_out = {1'b1, {(DW-1){1'b0}}};
		end else begin
			r4_c.x_slope_out = {1'b0, {(DW-1){1'b1}}};
		end
		r4_c.x_changed = r4_c.x_slope_out != last_c.sx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (!stall_s1) valid_s1 <= cell_valid;
			if (!stall_s2) valid_s2 <= valid_s1;
			if (!stall_s3) valid_s3 <= valid_s2;
			if (!stall_s4) valid_s4 <= chain_v[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1) begin
			dp_s1    <= EW'(right_c) - EW'(cell_data.cell_mean);
			dm_s1    <= EW'(cell_data.cell_mean) - EW'(left_c);
			dt_s1    <= EW'(top_c) - EW'(cell_data.cell_mean);
			db_s1    <= EW'(cell_data.cell_mean) - EW'(bot_c);
			sx_s1    <= cell_data.x_slope;
			sy_s1    <= cell_data.y_slope;
			has_y_s1 <= cell_data.has_y_slope;
			yen_s1   <= yen_q;
			mode_s1  <= mode_q;
		end
		if (!stall_s2) begin
			xmm_s2   <= mm3(MW'(sx_s1), MW'(dp_s1), MW'(dm_s1));
			ymm_s2   <= mm3(MW'(sy_s1), MW'(dt_s1), MW'(db_s1));
			sb1_s2   <= mm2(MW'(dp_s1), MW'(dm_s1) <<< 1);
			sb2_s2   <= mm2(MW'(dp_s1) <<< 1, MW'(dm_s1));
			mca_s2   <= MW'(dm_s1) <<< 1;
			mcb_s2   <= MW'(dp_s1) <<< 1;
			mcc_s2   <= half_c;
			dp_s2    <= dp_s1;
			dm_s2    <= dm_s1;
			sx_s2    <= sx_s1;
			sy_s2    <= sy_s1;
			has_y_s2 <= has_y_s1;
			yen_s2   <= yen_s1;
			mode_s2  <= mode_s1;
		end
		if (!stall_s3) begin
			data_s3 <= p3_c;
		end
		if (!stall_s4) begin
			res_s4 <= r4_c;
		end
	end

	assign chain_v[0] = valid_s3;
	assign chain_d[0] = data_s3;

	for (genvar g = 0; g < DW; g++) begin : g_div
		dgsl_hstep #(
			.BIT(DW - 1 - g)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_v[g]),
			.up_stall (chain_stall[g]),
			.up_data  (chain_d[g]),
			.dn_valid (chain_v[g+1]),
			.dn_stall (chain_stall[g+1]),
			.dn_data  (chain_d[g+1])
		);
	end

	assign res_valid = valid_s4;
	assign res       = res_s4;

endmodule

@@ test/dg_slope_limiter_test.sv @@
// Self-checking testbench for the dg_slope_limiter slope limiter pipeline.
// Depends on dgsl_pkg and dg_slope_limiter; predicts each result from the cell fields.
module dg_slope_limiter_test;

	localparam int DATA_WIDTH = dgsl_pkg::DATA_WIDTH;
	localparam int LATENCY = DATA_WIDTH + 4;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef dgsl_pkg::cell_t cell_t;
	typedef dgsl_pkg::result_t result_t;

	logic clk;
	logic arst_n;
	logic cell_valid;
	logic cell_stall;
	cell_t cell_data;
	logic res_valid;
	logic res_stall;
	result_t res;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [DATA_WIDTH-1:0] cfg_data;

	dg_slope_limiter dut (
		.clk(clk), .arst_n(arst_n),
		.cell_valid(cell_valid), .cell_stall(cell_stall), .cell_data(cell_data),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the configuration registers.
	logic [1:0] lim_mode;
	logic y_limit_on;
	logic signed [DATA_WIDTH-1:0] left_bnd;
	logic signed [DATA_WIDTH-1:0] right_bnd;

	cell_t pending_cells[$];
	result_t expected_slopes[$];
	int errors;
	int cells_sent;
	int slopes_checked;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_cycles;
	int quiet_cycles;
	int mode_hits[4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit same_sign(longint a, longint b);
		return (a > 0 && b > 0) || (a < 0 && b < 0);
	endfunction

	function automatic longint minmod2(longint a, longint b);
		if (!same_sign(a, b))
			return 0;
		return mag(a) < mag(b) ? a : b;
	endfunction

	function automatic longint minmod3(longint a, longint b, longint c);
		longint m;
		if (!same_sign(a, b) || !same_sign(a, c))
			return 0;
		m = mag(a);
		if (mag(b) < m)
			m = mag(b);
		if (mag(c) < m)
			m = mag(c);
		return a > 0 ? m : -m;
	endfunction

	// The product 2*|a|*|b| needs more than 64 bits.
	function automatic longint harmonic_slope(longint a, longint b);
		longint m;
		logic [95:0] x, y;
		if (!same_sign(a, b))
			return 0;
		x = 96'(mag(a));
		y = 96'(mag(b));
		m = longint'((2 * x * y) / (x + y));
		return a > 0 ? m : -m;
	endfunction

	function automatic longint clamp_mag(longint v, longint s);
		return mag(v) > mag(s) ? s : v;
	endfunction

	function automatic longint saturate(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic result_t limit_slopes(cell_t c);
		result_t r;
		longint mean, sx, sy, lft, rgt, dp, dm, lx, ly, s1, s2, bot, top;
		mean = c.cell_mean;
		sx = c.x_slope;
		sy = c.y_slope;
		lft = c.has_left ? longint'(c.left_mean) : longint'(left_bnd);
		rgt = c.has_right ? longint'(c.right_mean) : longint'(right_bnd);
		dp = rgt - mean;
		dm = mean - lft;
		case (lim_mode)
			dgsl_pkg::MODE_VANLEER: lx = clamp_mag(harmonic_slope(dm, dp), sx);
			dgsl_pkg::MODE_MC: lx = minmod3(2 * dm, 2 * dp, (dm + dp) / 2);
			dgsl_pkg::MODE_SUPERBEE: begin
				s1 = minmod2(dp, 2 * dm);
				s2 = minmod2(2 * dp, dm);
				lx = clamp_mag(mag(s1) >= mag(s2) ? s1 : s2, sx);
			end
			default: lx = minmod3(sx, dp, dm);
		endcase
		lx = saturate(lx);
		ly = 0;
		r.y_changed = 1'b0;
		if (c.has_y_slope) begin
			if (y_limit_on) begin
				bot = c.has_bottom ? longint'(c.bottom_mean) : 0;
				top = c.has_top ? longint'(c.top_mean) : 0;
				ly = saturate(minmod3(sy, top - mean, mean - bot));
				r.y_changed = (ly != sy);
			end else begin
				ly = sy;
			end
		end
		r.x_slope_out = lx[DATA_WIDTH-1:0];
		r.x_changed = (lx != sx);
		r.y_slope_out = ly[DATA_WIDTH-1:0];
		return r;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
			1: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
			2: return DATA_WIDTH'($urandom_range(0, 8)) - DATA_WIDTH'(4);
			3, 4, 5: return DATA_WIDTH'($signed($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	// Neighbor means sit near the cell mean most of the time so that the
	// limiters see both smooth and oscillating data.
	function automatic cell_t rand_cell();
		cell_t c;
		logic [DATA_WIDTH-1:0] base;
		bit near;
		near = $urandom_range(0, 3) != 0;
		base = rand_value();
		c.cell_mean = base;
		c.x_slope = near ? base - rand_value() / 4 - base : rand_value();
		c.left_mean = near ? base + DATA_WIDTH'($signed($urandom_range(0, 200000)) - 100000)
			: rand_value();
		c.right_mean = near ? base + DATA_WIDTH'($signed($urandom_range(0, 200000)) - 100000)
			: rand_value();
		c.y_slope = near ? DATA_WIDTH'($signed($urandom_range(0, 200000)) - 100000)
			: rand_value();
		c.bottom_mean = near ? base + DATA_WIDTH'($signed($urandom_range(0, 200000)) - 100000)
			: rand_value();
		c.top_mean = near ? base + DATA_WIDTH'($signed($urandom_range(0, 200000)) - 100000)
			: rand_value();
		c.has_left = $urandom_range(0, 4) != 0;
		c.has_right = $urandom_range(0, 4) != 0;
		c.has_y_slope = $urandom_range(0, 4) != 0;
		c.has_bottom = $urandom_range(0, 3) != 0;
		c.has_top = $urandom_range(0, 3) != 0;
		return c;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// Driver: a transfer happens when valid is high and stall is low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid <= 1'b0;
			cell_data <= '0;
		end else begin
			if (cell_valid && !cell_stall) begin
				expected_slopes.push_back(limit_slopes(cell_data));
				mode_hits[lim_mode]++;
				cells_sent++;
				void'(pending_cells.pop_front());
			end
			if (cell_valid && cell_stall) begin
				// hold the stalled transfer
			end else if (pending_cells.size() > 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				cell_valid <= 1'b1;
				cell_data <= pending_cells[0];
			end else begin
				cell_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare every result transfer with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			res_stall <= 1'b1;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_slopes.size() == 0) begin
					$display("result transfer with no prediction waiting");
					errors++;
				end else begin
					want = expected_slopes.pop_front();
					slopes_checked++;
					if (res.x_slope_out !== want.x_slope_out)
						report_mismatch("x_slope_out", res.x_slope_out, want.x_slope_out);
					if (res.x_changed !== want.x_changed)
						report_mismatch("x_changed", res.x_changed, want.x_changed);
					if (res.y_slope_out !== want.y_slope_out)
						report_mismatch("y_slope_out", res.y_slope_out, want.y_slope_out);
					if (res.y_changed !== want.y_changed)
						report_mismatch("y_changed", res.y_changed, want.y_changed);
				end
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= $urandom_range(0, 99) < recv_idle_pct;
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((cell_valid && !cell_stall) || (res_valid && !res_stall) || hold_off_cycles > 0)
			quiet_cycles <= 0;
		else if (pending_cells.size() > 0 || expected_slopes.size() > 0)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [DATA_WIDTH-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dgsl_pkg::REG_LIMITER_MODE: lim_mode = value[1:0];
			dgsl_pkg::REG_LIMIT_Y_EN: y_limit_on = value[0];
			dgsl_pkg::REG_LEFT_BOUNDARY: left_bnd = value;
			default: right_bnd = value;
		endcase
	endtask

	task automatic drain();
		wait (pending_cells.size() == 0 && !cell_valid && expected_slopes.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic directed_cells();
		cell_t c;
		logic [DATA_WIDTH-1:0] maxv, minv;
		maxv = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		minv = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		c = '0;
		c.has_left = 1; c.has_right = 1; c.has_y_slope = 1; c.has_bottom = 1; c.has_top = 1;
		// Smooth monotone data, then an extremum, then equal differences for ties.
		c.cell_mean = 100; c.left_mean = 50; c.right_mean = 200; c.x_slope = 80;
		c.bottom_mean = 40; c.top_mean = 300; c.y_slope = 500;
		pending_cells.push_back(c);
		c.right_mean = 20; pending_cells.push_back(c);
		c.right_mean = 150; c.x_slope = 50; pending_cells.push_back(c);
		c.right_mean = 125; c.x_slope = -7; pending_cells.push_back(c);
		// Opposite extremes of the means give the widest differences.
		c.cell_mean = maxv; c.left_mean = minv; c.right_mean = maxv; c.x_slope = maxv;
		c.y_slope = minv; c.bottom_mean = minv; c.top_mean = maxv;
		pending_cells.push_back(c);
		c.cell_mean = minv; c.left_mean = maxv; c.right_mean = minv; c.x_slope = minv;
		c.y_slope = maxv; c.bottom_mean = maxv; c.top_mean = minv;
		pending_cells.push_back(c);
		c.cell_mean = 0; c.left_mean = maxv; c.right_mean = minv; c.x_slope = minv;
		pending_cells.push_back(c);
		c.cell_mean = minv; c.left_mean = maxv; c.right_mean = maxv; c.x_slope = maxv;
		pending_cells.push_back(c);
		// Missing neighbors and a cell without a y slope term.
		c.cell_mean = 1000; c.x_slope = 300; c.y_slope = -300;
		c.has_left = 0; c.has_right = 0; c.has_bottom = 0; c.has_top = 0;
		pending_cells.push_back(c);
		c.has_y_slope = 0; pending_cells.push_back(c);
		c = '1; pending_cells.push_back(c);
		c = '0; pending_cells.push_back(c);
	endtask

	task automatic random_cells(int n);
		repeat (n) pending_cells.push_back(rand_cell());
	endtask

	initial begin
		logic [DATA_WIDTH-1:0] maxv, minv;
		maxv = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		minv = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		errors = 0; cells_sent = 0; slopes_checked = 0; quiet_cycles = 0;
		hold_off_cycles = 0; send_idle_pct = 28; recv_idle_pct = 68;
		lim_mode = dgsl_pkg::MODE_MINMOD; y_limit_on = 0; left_bnd = 0; right_bnd = 0;
		cfg_we = 1'b0; cfg_index = dgsl_pkg::REG_LIMITER_MODE; cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values first, then every mode with and without y limiting.
		directed_cells();
		drain();
		for (int m = 0; m < 4; m++) begin
			for (int y = 0; y < 2; y++) begin
				write_reg(dgsl_pkg::REG_LIMITER_MODE, DATA_WIDTH'(m));
				write_reg(dgsl_pkg::REG_LIMIT_Y_EN, DATA_WIDTH'(y));
				write_reg(dgsl_pkg::REG_LEFT_BOUNDARY,
					(m == 1) ? maxv : (m == 2) ? minv : rand_value());
				write_reg(dgsl_pkg::REG_RIGHT_BOUNDARY,
					(m == 1) ? minv : (m == 3) ? maxv : rand_value());
				if (m == 1 && y == 1)
					directed_cells();
				if (m == 2 && y == 0) begin
					send_idle_pct = 68; recv_idle_pct = 28;
				end
				if (m == 3 && y == 0) begin
					send_idle_pct = 0; recv_idle_pct = 0;
					// Long receiver hold-off while cells keep coming.
					hold_off_cycles = 4 * LATENCY;
				end
				random_cells(240);
				drain();
			end
		end

		$display("checked %0d results from %0d cells; per mode %0d/%0d/%0d/%0d",
			slopes_checked, cells_sent, mode_hits[0], mode_hits[1], mode_hits[2],
			mode_hits[3]);
		if (errors == 0 && expected_slopes.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
